@@ sv/rs1110_pkg.sv @@
`timescale 1ns / 1ps

package rs1110_pkg;

  // Default sample width of one complex component.
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Resampling period and interpolation divisor.
  localparam int unsigned PERIOD_IN  = 11;
  localparam int unsigned INTERP_DIV = 10;

  localparam int unsigned PHASE_BITS  = 4;
  localparam int unsigned FACTOR_BITS = 9;
  localparam int unsigned COUNT_BITS  = 8;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [PHASE_BITS-1:0] PHASE_COPY = PHASE_BITS'(0);
  localparam logic [PHASE_BITS-1:0] PHASE_HOLD = PHASE_BITS'(1);
  localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(PERIOD_IN - 1);

  localparam logic [FACTOR_BITS-1:0] FACTOR_MIN = FACTOR_BITS'(1);
  localparam logic [FACTOR_BITS-1:0] FACTOR_MAX = FACTOR_BITS'(256);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESAMPLE_EN  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DECIM_FACTOR = CFG_IDX_BITS'(1);

  // Register load strobes for one datapath lane.
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_out;
  } lane_ctrl_t;

endpackage

@@ sv/rs1110_lane.sv @@
`timescale 1ns / 1ps

// One component lane: weighted sum of two samples, then exact division by
// ten rounded toward zero, through two pipeline registers and a result register.
module rs1110_lane #(
  parameter int unsigned SAMPLE_BITS = rs1110_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  rs1110_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       a_i,
  input  logic signed [SAMPLE_BITS-1:0]       b_i,
  input  logic [rs1110_pkg::PHASE_BITS-1:0]   k_i,
  output logic signed [SAMPLE_BITS-1:0]       res_o
);

  // |sum| <= 10 * 2^(SAMPLE_BITS-1) < 2^(SAMPLE_BITS+3).
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + 4;
  localparam int unsigned MAG_BITS  = SAMPLE_BITS + 3;
  localparam int unsigned SHIFT     = MAG_BITS + 4;
  localparam int unsigned RCP_BITS  = MAG_BITS + 1;
  localparam int unsigned PROD_BITS = MAG_BITS + RCP_BITS;
  // Rounded-up reciprocal of ten; exact for every magnitude below 2^MAG_BITS.
  localparam logic [RCP_BITS-1:0] RECIP = RCP_BITS'(((64'd1 << SHIFT)
      + 64'(rs1110_pkg::INTERP_DIV) - 64'd1) / 64'(rs1110_pkg::INTERP_DIV));

  logic signed [SAMPLE_BITS-1:0]      a_q, b_q;
  logic [rs1110_pkg::PHASE_BITS-1:0]  k_q;
  logic [rs1110_pkg::PHASE_BITS-1:0]  w;
  logic signed [SUM_BITS-1:0]         a_ext, b_ext, k_ext, w_ext, sum;
  logic [SUM_BITS-1:0]                sum_abs;
  logic                               neg_d, neg_q;
  logic [MAG_BITS-1:0]                mag_d, mag_q;
  logic [PROD_BITS-1:0]               prod;
  logic [SAMPLE_BITS-1:0]             qmag;
  logic signed [SAMPLE_BITS-1:0]      res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s1) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= k_i;
    end
  end

  always_comb begin
    w       = rs1110_pkg::PHASE_BITS'(rs1110_pkg::INTERP_DIV) - k_q;
    a_ext   = SUM_BITS'(a_q);
    b_ext   = SUM_BITS'(b_q);
    k_ext   = $signed(SUM_BITS'(k_q));
    w_ext   = $signed(SUM_BITS'(w));
    sum     = a_ext * w_ext + b_ext * k_ext;
    neg_d   = sum[SUM_BITS-1];
    sum_abs = neg_d ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    mag_d   = sum_abs[MAG_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s2) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
  end

  always_comb begin
    prod  = PROD_BITS'(mag_q) * PROD_BITS'(RECIP);
    qmag  = prod[SHIFT +: SAMPLE_BITS];
    res_d = neg_q ? $signed(-qmag) : $signed(qmag);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_out) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ sv/resample_11_to_10_decimate_unit.sv @@
`timescale 1ns / 1ps
// A kept sample goes through the stage-one, stage-two and output registers before it is offered.
// Throughput: one input transfer per cycle, limited only by output stall back-pressure.
// The weighted sum and the divide-by-ten multiplier each have a pipeline register of their own.
// Reset (rst_ni, asynchronous, active low) clears the pipeline valid flags, the period phase,
// the previous sample, the decimation count, and sets resampling off with a factor of one.
module resample_11_to_10_decimate_unit #(
  parameter int unsigned SAMPLE_BITS = rs1110_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_im_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]         out_re_o,
  output logic signed [SAMPLE_BITS-1:0]         out_im_o,
  input  logic                                  cfg_we_i,
  input  logic [rs1110_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rs1110_pkg::FACTOR_BITS-1:0]    cfg_data_i
);

  // Configuration registers.
  logic                                 resample_en_q;
  logic [rs1110_pkg::FACTOR_BITS-1:0]   factor_q;

  // Period and decimation state.
  logic [rs1110_pkg::PHASE_BITS-1:0]    phase_q, phase_d;
  logic signed [SAMPLE_BITS-1:0]        prev_re_q, prev_im_q;
  logic [rs1110_pkg::COUNT_BITS-1:0]    count_q, count_d;

  // Pipeline valid flags: stage one, stage two, output register.
  logic v1_q, v2_q, vo_q;
  logic rdy_o, rdy2, rdy1, accept, have, keep;

  logic [rs1110_pkg::FACTOR_BITS-1:0]   factor;
  logic [rs1110_pkg::FACTOR_BITS-1:0]   count_inc;

  // Operands handed to the lanes: output is ((10-k)*a + k*b)/10.
  logic signed [SAMPLE_BITS-1:0]        a_re, a_im, b_re, b_im;
  logic [rs1110_pkg::PHASE_BITS-1:0]    k;

  rs1110_pkg::lane_ctrl_t               ctrl;

  // Configuration writes; the user must write only while idle, as the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resample_en_q <= 1'b0;
      factor_q      <= rs1110_pkg::FACTOR_MIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rs1110_pkg::CFG_RESAMPLE_EN:  resample_en_q <= cfg_data_i[0];
        rs1110_pkg::CFG_DECIM_FACTOR: factor_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each stage advances when the stage after it is empty or moving on, so the
  // pipeline keeps taking transfers while the output waits, until it is full.
  assign rdy_o      = !vo_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy_o;
  assign rdy1       = !v1_q || rdy2;
  assign accept     = in_valid_i && rdy1;
  assign in_stall_o = !rdy1;

  // Candidate selection. With resampling on, phase zero copies its sample
  // (k of zero gives 10*x/10), phase one only stores its sample, and later
  // phases blend the stored sample with the current one. With resampling off
  // every sample passes through unchanged and the period state is frozen.
  always_comb begin
    have    = 1'b1;
    a_re    = sample_re_i;
    a_im    = sample_im_i;
    b_re    = sample_re_i;
    b_im    = sample_im_i;
    k       = '0;
    phase_d = phase_q;
    if (resample_en_q) begin
      phase_d = (phase_q == rs1110_pkg::PHASE_LAST) ? '0 : phase_q + 1'b1;
      if (phase_q == rs1110_pkg::PHASE_HOLD) begin
        have = 1'b0;
      end else if (phase_q != rs1110_pkg::PHASE_COPY) begin
        a_re = prev_re_q;
        a_im = prev_im_q;
        k    = phase_q - 1'b1;
      end
    end
  end

  // Decimation: the first candidate is kept, then one in every factor. A zero
  // factor acts as one and anything above the maximum acts as the maximum.
  always_comb begin
    if (factor_q == '0) begin
      factor = rs1110_pkg::FACTOR_MIN;
    end else if (factor_q > rs1110_pkg::FACTOR_MAX) begin
      factor = rs1110_pkg::FACTOR_MAX;
    end else begin
      factor = factor_q;
    end
    count_inc = rs1110_pkg::FACTOR_BITS'(count_q) + 1'b1;
    count_d   = (count_inc >= factor) ? '0 : count_inc[rs1110_pkg::COUNT_BITS-1:0];
    keep      = have && (count_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      prev_re_q <= '0;
      prev_im_q <= '0;
      count_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      if (resample_en_q) begin
        prev_re_q <= sample_re_i;
        prev_im_q <= sample_im_i;
      end
      if (have) begin
        count_q <= count_d;
      end
    end
  end

  // Dropped candidates enter the pipeline as bubbles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= accept && keep;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy_o) begin
        vo_q <= v2_q;
      end
    end
  end

  assign ctrl.ld_s1  = accept && keep;
  assign ctrl.ld_s2  = v1_q && rdy2;
  assign ctrl.ld_out = v2_q && rdy_o;

  rs1110_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_re (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .a_i   (a_re),
    .b_i   (b_re),
    .k_i   (k),
    .res_o (out_re_o)
  );

  rs1110_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_im (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .a_i   (a_im),
    .b_i   (b_im),
    .k_i   (k),
    .res_o (out_im_o)
  );

  assign out_valid_o = vo_q;

endmodule
